[sv/pset_pkg.sv]
// ----------------------------------------------------------------------------
// pset_pkg: shared definitions for the scanline edge table unit
// Table sizes, fixed-point widths, command codes, controller states and the
// control/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package pset_pkg;

    // table geometry
    localparam int ROWS   = 1024;
    localparam int COLS   = 1024;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int LEFT_W = $clog2(COLS + 1);

    // width of the coordinate fields on the ports
    localparam int IN_W   = 10;

    // q.16 fixed point for the x walk
    localparam int FRAC_W = 16;
    localparam int X_W    = IN_W + FRAC_W + 2;
    localparam int DIV_W  = IN_W + FRAC_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // commands
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVGO,
        ST_DIV,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_step;
        logic div_start;
        logic walk_init;
        logic walk_step;
        logic resp;
    } pset_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic walk_last;
    } pset_sts_t;

    // integer part of a q.16 x, clamped to the column range
    function automatic logic [COL_W-1:0] stored_x(input logic signed [X_W-1:0] x);
        logic [X_W-FRAC_W-2:0] ip;
        logic [COL_W-1:0]      res;
        ip = x[X_W-2:FRAC_W];
        if (x[X_W-1])
        begin
            res = '0;
        end
        else if (ip > (X_W-FRAC_W-1)'(COLS - 1))
        begin
            res = COL_W'(COLS - 1);
        end
        else
        begin
            res = ip[COL_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/polygon_scanline_edge_table_unit.sv]
// Clear: busy while every table row is rewritten, one table row written per cycle.
// Add edge: busy through a setup state, the bit-serial slope divide, the walk
//   at one row per cycle and a drain state.
// Read row: the span strobe follows the transfer through the read and response states.
// Reset starts a clearing pass with busy high; results are a one-cycle strobe
//   that the receiver cannot stall.
// ----------------------------------------------------------------------------
// polygon_scanline_edge_table_unit: scanline polygon fill edge tables
// Keeps per-row left/right edge extents, rasterizes added edges in q.16
// fixed point and returns the fill span of a requested row.
// ----------------------------------------------------------------------------
module polygon_scanline_edge_table_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  cmd,
    input  logic [pset_pkg::IN_W-1:0]   edge_x_start,
    input  logic [pset_pkg::IN_W-1:0]   edge_y_start,
    input  logic [pset_pkg::IN_W-1:0]   edge_x_end,
    input  logic [pset_pkg::IN_W-1:0]   edge_y_end,
    input  logic [pset_pkg::IN_W-1:0]   query_row,
    output logic                        span_valid,
    output logic [pset_pkg::IN_W-1:0]   span_row,
    output logic [pset_pkg::LEFT_W-1:0] span_left,
    output logic [pset_pkg::COL_W-1:0]  span_right,
    output logic                        span_touched
);
    import pset_pkg::*;

    pset_ctl_t ctl;
    pset_sts_t sts;

    // sequencer
    pset_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    // tables and arithmetic
    pset_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .edge_x_start (edge_x_start),
        .edge_y_start (edge_y_start),
        .edge_x_end   (edge_x_end),
        .edge_y_end   (edge_y_end),
        .query_row    (query_row),
        .span_valid   (span_valid),
        .span_row     (span_row),
        .span_left    (span_left),
        .span_right   (span_right),
        .span_touched (span_touched)
    );

endmodule

[sv/pset_div.sv]
// ----------------------------------------------------------------------------
// pset_div: restoring divider for the edge slope
// Unsigned divide, one quotient bit per cycle; done pulses with the final
// quotient in the register.
// ----------------------------------------------------------------------------
module pset_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pset_pkg::DIV_W-1:0] dividend,
    input  logic [pset_pkg::IN_W-1:0]  divisor,
    output logic [pset_pkg::DIV_W-1:0] quotient,
    output logic                       done
);
    import pset_pkg::*;

    logic [IN_W-1:0]   rem_reg;
    logic [IN_W-1:0]   rem_next;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [IN_W:0]     shifted;
    logic [IN_W:0]     diff;
    logic              ge;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = shifted >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = DCNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[IN_W-1:0] : shifted[IN_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[sv/pset_datapath.sv]
// ----------------------------------------------------------------------------
// pset_datapath: edge tables, slope divider, x walk and span output
// Holds the left/right tables as single-port-write memories with registered
// reads, walks an edge one row per cycle through a two-stage
// read-modify-write, and sweeps the tables on clear.
// ----------------------------------------------------------------------------
module pset_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pset_pkg::pset_ctl_t         ctl,
    output pset_pkg::pset_sts_t         sts,
    input  logic [pset_pkg::IN_W-1:0]   edge_x_start,
    input  logic [pset_pkg::IN_W-1:0]   edge_y_start,
    input  logic [pset_pkg::IN_W-1:0]   edge_x_end,
    input  logic [pset_pkg::IN_W-1:0]   edge_y_end,
    input  logic [pset_pkg::IN_W-1:0]   query_row,
    output logic                        span_valid,
    output logic [pset_pkg::IN_W-1:0]   span_row,
    output logic [pset_pkg::LEFT_W-1:0] span_left,
    output logic [pset_pkg::COL_W-1:0]  span_right,
    output logic                        span_touched
);
    import pset_pkg::*;

    // captured edge, ordered so y rises
    logic [IN_W-1:0]        xa_reg;
    logic [IN_W-1:0]        ya_reg;
    logic [IN_W-1:0]        yb_reg;
    logic signed [IN_W:0]   dx_reg;
    logic [IN_W-1:0]        dy_reg;
    logic [IN_W-1:0]        qrow_reg;
    logic                   swap;
    logic [IN_W-1:0]        xa_in;
    logic [IN_W-1:0]        xb_in;
    logic [IN_W-1:0]        ya_in;
    logic [IN_W-1:0]        yb_in;

    // slope
    logic [IN_W:0]          dx_neg;
    logic [DIV_W-1:0]       quotient;
    logic                   div_done;
    logic [X_W-1:0]         q_ext;
    logic signed [X_W-1:0]  slope;
    logic signed [X_W-1:0]  slope_reg;

    // walk
    logic signed [X_W-1:0]  x_reg;
    logic [IN_W-1:0]        y_reg;
    logic                   y_in_table;
    logic                   s1_valid_reg;
    logic signed [X_W-1:0]  s1_x_reg;
    logic [ROW_W-1:0]       s1_row_reg;

    // tables
    logic [LEFT_W-1:0]      left_mem [ROWS];
    logic [COL_W-1:0]       right_mem [ROWS];
    logic [LEFT_W-1:0]      rd_left_reg;
    logic [COL_W-1:0]       rd_right_reg;
    logic [ROW_W-1:0]       rd_addr;
    logic [ROW_W-1:0]       wr_addr;
    logic                   mem_we;
    logic [LEFT_W-1:0]      wr_left;
    logic [COL_W-1:0]       wr_right;
    logic [ROW_W-1:0]       clr_cnt_reg;

    // row update
    logic signed [X_W-1:0]  x_left;
    logic signed [X_W-1:0]  x_right;
    logic [COL_W-1:0]       x_stored;
    logic                   upd_left;
    logic                   upd_right;

    // span output
    logic                   q_in_table;
    logic [LEFT_W-1:0]      resp_left;
    logic [COL_W-1:0]       resp_right;
    logic                   span_valid_reg;
    logic [IN_W-1:0]        span_row_reg;
    logic [LEFT_W-1:0]      span_left_reg;
    logic [COL_W-1:0]       span_right_reg;
    logic                   span_touched_reg;

    // endpoint ordering
    always_comb
    begin
        swap  = edge_y_end < edge_y_start;
        xa_in = swap ? edge_x_end   : edge_x_start;
        ya_in = swap ? edge_y_end   : edge_y_start;
        xb_in = swap ? edge_x_start : edge_x_end;
        yb_in = swap ? edge_y_start : edge_y_end;
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            xa_reg   <= xa_in;
            ya_reg   <= ya_in;
            yb_reg   <= yb_in;
            dx_reg   <= $signed({1'b0, xb_in}) - $signed({1'b0, xa_in});
            dy_reg   <= yb_in - ya_in;
            qrow_reg <= query_row;
        end
    end

    // magnitude of dx, shifted into q.16, through the divider
    assign dx_neg = -dx_reg;

    pset_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend ({(dx_reg[IN_W] ? dx_neg[IN_W-1:0] : dx_reg[IN_W-1:0]),
                    {FRAC_W{1'b0}}}),
        .divisor  (dy_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // signed slope; a flat edge steps by dx
    always_comb
    begin
        q_ext = {2'b00, quotient};
        if (dy_reg == '0)
        begin
            slope = {dx_reg[IN_W], dx_reg, {FRAC_W{1'b0}}};
        end
        else if (dx_reg[IN_W])
        begin
            slope = -$signed(q_ext);
        end
        else
        begin
            slope = $signed(q_ext);
        end
    end

    // x walk, one row per step
    assign y_in_table = int'(y_reg) < ROWS;

    always_ff @(posedge clk)
    begin
        if (ctl.walk_init)
        begin
            slope_reg <= slope;
            x_reg     <= {2'b00, xa_reg, {FRAC_W{1'b0}}};
            y_reg     <= ya_reg;
        end
        else if (ctl.walk_step)
        begin
            x_reg <= x_reg + slope_reg;
            y_reg <= y_reg + 1'b1;
        end
        s1_x_reg   <= x_reg;
        s1_row_reg <= ROW_W'(y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.walk_step && y_in_table;
        end
    end

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_init)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // status back to the sequencer
    always_comb
    begin
        sts.clr_last  = (clr_cnt_reg == ROW_W'(ROWS - 1));
        sts.div_done  = div_done;
        sts.walk_last = (y_reg == yb_reg);
    end

    // min/max against the stored row
    always_comb
    begin
        x_left    = $signed({1'b0, rd_left_reg, {FRAC_W{1'b0}}});
        x_right   = $signed({2'b00, rd_right_reg, {FRAC_W{1'b0}}});
        x_stored  = stored_x(s1_x_reg);
        upd_left  = s1_x_reg < x_left;
        upd_right = s1_x_reg > x_right;
    end

    // table write port: clear sweep or walk write-back
    always_comb
    begin
        mem_we = ctl.clr_step || s1_valid_reg;
        if (ctl.clr_step)
        begin
            wr_addr  = clr_cnt_reg;
            wr_left  = LEFT_W'(COLS);
            wr_right = '0;
        end
        else
        begin
            wr_addr  = s1_row_reg;
            wr_left  = upd_left ? LEFT_W'(x_stored) : rd_left_reg;
            wr_right = upd_right ? x_stored : rd_right_reg;
        end
    end

    // table read port: walk row or query row
    assign rd_addr = ctl.walk_step ? ROW_W'(y_reg) : ROW_W'(qrow_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            left_mem[wr_addr] <= wr_left;
        end
        rd_left_reg <= left_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            right_mem[wr_addr] <= wr_right;
        end
        rd_right_reg <= right_mem[rd_addr];
    end

    // span result
    always_comb
    begin
        q_in_table = int'(qrow_reg) < ROWS;
        resp_left  = q_in_table ? rd_left_reg  : LEFT_W'(COLS);
        resp_right = q_in_table ? rd_right_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_valid_reg <= 1'b0;
        end
        else
        begin
            span_valid_reg <= ctl.resp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.resp)
        begin
            span_row_reg     <= qrow_reg;
            span_left_reg    <= resp_left;
            span_right_reg   <= resp_right;
            span_touched_reg <= resp_left <= {1'b0, resp_right};
        end
    end

    assign span_valid   = span_valid_reg;
    assign span_row     = span_row_reg;
    assign span_left    = span_left_reg;
    assign span_right   = span_right_reg;
    assign span_touched = span_touched_reg;

endmodule

[sv/pset_ctrl.sv]
// ----------------------------------------------------------------------------
// pset_ctrl: command sequencer
// Decodes each accepted command and steps the datapath through the clear
// sweep, slope divide, row walk or table read.
// ----------------------------------------------------------------------------
module pset_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    output logic                busy,
    output pset_pkg::pset_ctl_t ctl,
    input  pset_pkg::pset_sts_t sts
);
    import pset_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register; reset enters the clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            ctl.clr_init = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            state_next = ST_DIVGO;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIVGO:
            begin
                ctl.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                ctl.resp   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[sv/pset_checker.sv]
// ----------------------------------------------------------------------------
// pset_checker: port-level checks for the scanline edge table unit
// Watches command transfers and span strobes on the top-level ports.
// ----------------------------------------------------------------------------
module pset_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  cmd,
    input logic [pset_pkg::IN_W-1:0]   edge_x_start,
    input logic [pset_pkg::IN_W-1:0]   edge_y_start,
    input logic [pset_pkg::IN_W-1:0]   edge_x_end,
    input logic [pset_pkg::IN_W-1:0]   edge_y_end,
    input logic [pset_pkg::IN_W-1:0]   query_row,
    input logic                        span_valid,
    input logic [pset_pkg::IN_W-1:0]   span_row,
    input logic [pset_pkg::LEFT_W-1:0] span_left,
    input logic [pset_pkg::COL_W-1:0]  span_right,
    input logic                        span_touched
);
    import pset_pkg::*;

    // span strobe lasts a single cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |=> !span_valid)
        else $error("span strobe held longer than one cycle");

    // a read transfer returns a span strobe for its row
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_READ) |->
            ##3 (span_valid && span_row == $past(query_row, 3)))
        else $error("read span missing or for the wrong row");

    // touched flag agrees with the span bounds
    a_touched: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (span_touched == (span_left <= {1'b0, span_right})))
        else $error("span touched flag inconsistent");

    // left bound never exceeds the untouched marker
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (span_left <= LEFT_W'(COLS)))
        else $error("span left out of range");

    // any real command transfer makes the unit busy
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_NONE) |=> busy)
        else $error("unit not busy after command transfer");

endmodule

bind polygon_scanline_edge_table_unit pset_checker u_checker (.*);

[tb/sv/polygon_scanline_edge_table_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_scanline_edge_table_unit_tb: self-checking bench for the edge tables
// Drives clear, add-edge, read-row and unused commands through the start/busy
// handshake. A directed table covers extremes, slope directions and clears.
// It is followed by random polygons with row reads mostly inside their extent. A
// q.16 shadow of both edge tables predicts each span strobe that the directed
// table does not type; every strobe is compared field by field.
// ----------------------------------------------------------------------------
module polygon_scanline_edge_table_unit_tb;

    import pset_pkg::*;

    localparam int    ITEMS       = 1500;
    localparam int    QUIET_TAIL  = 150;
    localparam int    SETTLE      = 1100;
    localparam int    CYCLE_LIMIT = 8_000_000;
    localparam longint FRAC_ONE   = 64'sd65536;

    // one span strobe as seen on the result ports
    typedef struct packed {
        logic [IN_W-1:0]   row;
        logic [LEFT_W-1:0] left;
        logic [COL_W-1:0]  right;
        logic              touched;
    } span_t;

    // one directed command, with a typed span where it is obvious
    typedef struct packed {
        cmd_t              op;
        logic [IN_W-1:0]   xs;
        logic [IN_W-1:0]   ys;
        logic [IN_W-1:0]   xe;
        logic [IN_W-1:0]   ye;
        logic [IN_W-1:0]   qr;
        logic              known;
        span_t             span;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        cmd;
    logic [IN_W-1:0]   edge_x_start;
    logic [IN_W-1:0]   edge_y_start;
    logic [IN_W-1:0]   edge_x_end;
    logic [IN_W-1:0]   edge_y_end;
    logic [IN_W-1:0]   query_row;
    logic              span_valid;
    logic [IN_W-1:0]   span_row;
    logic [LEFT_W-1:0] span_left;
    logic [COL_W-1:0]  span_right;
    logic              span_touched;

    // shadow edge tables
    logic [LEFT_W-1:0] left_edge [ROWS];
    logic [COL_W-1:0]  right_edge [ROWS];

    span_t    pending_spans [$];
    dir_row_t dir_rows [$];
    int       fail_count = 0;
    int       cycles = 0;
    bit       gaps_on = 1'b1;

    polygon_scanline_edge_table_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .edge_x_start (edge_x_start),
        .edge_y_start (edge_y_start),
        .edge_x_end   (edge_x_end),
        .edge_y_end   (edge_y_end),
        .query_row    (query_row),
        .span_valid   (span_valid),
        .span_row     (span_row),
        .span_left    (span_left),
        .span_right   (span_right),
        .span_touched (span_touched)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // reset every row to the untouched span
    task automatic wipe_tables();
        for (int r = 0; r < ROWS; r++)
        begin
            left_edge[r]  = LEFT_W'(COLS);
            right_edge[r] = '0;
        end
    endtask

    // integer column of a q.16 x, clamped to the table width
    function automatic logic [COL_W-1:0] column_of(input longint x);
        longint v;
        if (x < 0)
        begin
            return '0;
        end
        v = x / FRAC_ONE;
        if (v > COLS - 1)
        begin
            v = COLS - 1;
        end
        return v[COL_W-1:0];
    endfunction

    // walk an edge bottom to top and widen each row it crosses
    task automatic trace_edge(input longint xa, input longint ya,
                              input longint xb, input longint yb);
        longint t;
        longint dx;
        longint dy;
        longint slope;
        longint x;
        if (yb < ya)
        begin
            t = ya; ya = yb; yb = t;
            t = xa; xa = xb; xb = t;
        end
        dx = xb - xa;
        dy = yb - ya;
        slope = (dy != 0) ? (dx * FRAC_ONE) / dy : dx * FRAC_ONE;
        x = xa * FRAC_ONE;
        for (longint y = ya; y <= yb; y++)
        begin
            if (y < ROWS)
            begin
                if (x < longint'(left_edge[y]) * FRAC_ONE)
                begin
                    left_edge[y] = LEFT_W'(column_of(x));
                end
                if (x > longint'(right_edge[y]) * FRAC_ONE)
                begin
                    right_edge[y] = column_of(x);
                end
            end
            x += slope;
        end
    endtask

    // one command transfer, table update at the accepting edge, optional gap
    task automatic issue(input cmd_t op, input logic [IN_W-1:0] xs,
                         input logic [IN_W-1:0] ys, input logic [IN_W-1:0] xe,
                         input logic [IN_W-1:0] ye, input logic [IN_W-1:0] qr,
                         input logic known, input span_t typed);
        span_t want;
        start        <= 1'b1;
        cmd          <= op;
        edge_x_start <= xs;
        edge_y_start <= ys;
        edge_x_end   <= xe;
        edge_y_end   <= ye;
        query_row    <= qr;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        case (op)
            CMD_CLEAR: wipe_tables();
            CMD_ADD:   trace_edge(xs, ys, xe, ye);
            CMD_READ:
            begin
                want.row = qr;
                if (qr < ROWS)
                begin
                    want.left  = left_edge[qr];
                    want.right = right_edge[qr];
                end
                else
                begin
                    want.left  = LEFT_W'(COLS);
                    want.right = '0;
                end
                want.touched = (want.left <= want.right);
                pending_spans.push_back(known ? typed : want);
            end
            default: ;
        endcase
        if (gaps_on && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding span has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_spans.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // span checker
    always @(posedge clk)
    begin
        span_t got;
        span_t want;
        if (rst_n && span_valid)
        begin
            got = {span_row, span_left, span_right, span_touched};
            if (pending_spans.size() == 0)
            begin
                $display("%0t: unexpected span row %0d left %0d right %0d touched %0d",
                         $time, got.row, got.left, got.right, got.touched);
                fail_count++;
            end
            else
            begin
                want = pending_spans.pop_front();
                if (got !== want)
                begin
                    $display("%0t: span mismatch expected row %0d left %0d right %0d touched %0d",
                             $time, want.row, want.left, want.right, want.touched);
                    $display("%0t:               actual   row %0d left %0d right %0d touched %0d",
                             $time, got.row, got.left, got.right, got.touched);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        dir_row_t dr;
        span_t    none;
        int       sent;
        int       nv;
        int       height;
        int       width;
        int       ybase;
        int       xbase;
        int       nr;
        int       vx [8];
        int       vy [8];
        logic [IN_W-1:0] qr;

        none         = '0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_NONE;
        edge_x_start = '0;
        edge_y_start = '0;
        edge_x_end   = '0;
        edge_y_end   = '0;
        query_row    = '0;
        wipe_tables();

        // directed commands: extremes, both slope signs, flat and upright edges
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1,
                             '{10'd0, 11'd1024, 10'd0, 1'b0}});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b1,
                             '{10'd1023, 11'd1024, 10'd0, 1'b0}});
        dir_rows.push_back('{CMD_ADD, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd511, 1'b0, '0});
        dir_rows.push_back('{CMD_ADD, 10'd1023, 10'd700, 10'd0, 10'd300, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_ADD, 10'd100, 10'd5, 10'd900, 10'd5, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_ADD, 10'd500, 10'd100, 10'd500, 10'd200, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_ADD, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_NONE, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd5, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd150, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd400, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd700, 1'b0, '0});
        dir_rows.push_back('{CMD_ADD, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b0, '0});
        dir_rows.push_back('{CMD_CLEAR, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1,
                             '{10'd0, 11'd1024, 10'd0, 1'b0}});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b1,
                             '{10'd1023, 11'd1024, 10'd0, 1'b0}});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd5, 1'b1,
                             '{10'd5, 11'd1024, 10'd0, 1'b0}});
        dir_rows.push_back('{CMD_ADD, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1,
                             '{10'd0, 11'd0, 10'd0, 1'b1}});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, unused fields filled with noise
        foreach (dir_rows[i])
        begin
            dr = dir_rows[i];
            if (dr.op == CMD_ADD)
            begin
                issue(dr.op, dr.xs, dr.ys, dr.xe, dr.ye, IN_W'($urandom),
                      dr.known, dr.span);
            end
            else if (dr.op == CMD_READ)
            begin
                issue(dr.op, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), dr.qr, dr.known, dr.span);
            end
            else
            begin
                issue(dr.op, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), IN_W'($urandom), 1'b0, none);
            end
        end
        drain();

        // random polygons: optional clear, closed outline, reads mostly in its extent
        sent = 0;
        while (sent < ITEMS)
        begin
            if ($urandom_range(7) == 0)
            begin
                issue(CMD_CLEAR, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), IN_W'($urandom), 1'b0, none);
                sent++;
            end
            nv     = $urandom_range(3, 6);
            height = ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(63);
            width  = ($urandom_range(3) == 0) ? 1023 : $urandom_range(1023);
            ybase  = $urandom_range(1023 - height);
            xbase  = $urandom_range(1023 - width);
            for (int v = 0; v < nv; v++)
            begin
                vx[v] = xbase + $urandom_range(width);
                vy[v] = ybase + $urandom_range(height);
            end
            for (int v = 0; v < nv; v++)
            begin
                issue(CMD_ADD, IN_W'(vx[v]), IN_W'(vy[v]), IN_W'(vx[(v + 1) % nv]),
                      IN_W'(vy[(v + 1) % nv]), IN_W'($urandom), 1'b0, none);
                sent++;
                // stray unused command or an edge with random endpoints now and then
                if ($urandom_range(15) == 0)
                begin
                    issue(CMD_NONE, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                          IN_W'($urandom), IN_W'($urandom), 1'b0, none);
                end
                else if ($urandom_range(31) == 0)
                begin
                    issue(CMD_ADD, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                          IN_W'($urandom), IN_W'($urandom), 1'b0, none);
                    sent++;
                end
            end
            nr = $urandom_range(4, 12);
            for (int k = 0; k < nr; k++)
            begin
                qr = ($urandom_range(9) == 0) ? IN_W'($urandom)
                                              : IN_W'(ybase + $urandom_range(height));
                issue(CMD_READ, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), qr, 1'b0, none);
                sent++;
            end
            // idling comes and goes, and stops for the tail of the run
            if ($urandom_range(5) == 0)
            begin
                gaps_on = !gaps_on;
            end
            if (sent >= ITEMS - QUIET_TAIL)
            begin
                gaps_on = 1'b0;
            end
            // sender holds off until all spans are back, now and then
            if ($urandom_range(19) == 0)
            begin
                drain();
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/pset_pkg.sv
sv/pset_div.sv
sv/pset_datapath.sv
sv/pset_ctrl.sv
sv/polygon_scanline_edge_table_unit.sv
sv/pset_checker.sv
tb/sv/polygon_scanline_edge_table_unit_tb.sv
